// ===== design/pdpc_pkg.sv =====
package pdpc_pkg;

   // Default rotation resolution: steps per turn is two to this power.
   localparam int TRIG_TABLE_BITS_DEF = 10;

   // Register map, in word order.
   localparam logic [2:0] CSR_GAIN_P_X      = 3'd0;
   localparam logic [2:0] CSR_GAIN_D_X      = 3'd1;
   localparam logic [2:0] CSR_GAIN_P_Y      = 3'd2;
   localparam logic [2:0] CSR_GAIN_D_Y      = 3'd3;
   localparam logic [2:0] CSR_GAIN_P_TURN   = 3'd4;
   localparam logic [2:0] CSR_GAIN_D_TURN   = 3'd5;
   localparam logic [2:0] CSR_STEP_PERIOD   = 3'd6;
   localparam int         CSR_ADDR_W        = 5;

   // Register reset values.
   localparam logic signed [15:0] GAIN_P_RESET = 16'sd256;
   localparam logic signed [15:0] GAIN_D_RESET = 16'sd0;
   localparam logic [15:0]        PERIOD_RESET = 16'd1000;

   // Heading arithmetic: one turn is 360 degrees in 1/256 degree units.
   localparam logic [16:0] TURN_UNITS   = 17'd92160;
   localparam logic [16:0] HALF_TURN    = 17'd46080;
   // A whole number of turns that lifts any 24-bit heading above zero.
   localparam logic [24:0] TURN_OFFSET  = 25'd8478720;

   // CORDIC constants.
   localparam int                 CORDIC_STEPS = 16;
   localparam logic signed [33:0] CORDIC_GAIN  = 34'sd652032874;

   // Arctangent of 2^-k in units of 2^32 per turn.
   function automatic logic [29:0] atan_turn(input logic [3:0] k);
      logic [29:0] a;
      unique case (k)
         4'd0:  a = 30'd536870912;
         4'd1:  a = 30'd316933406;
         4'd2:  a = 30'd167458907;
         4'd3:  a = 30'd85004756;
         4'd4:  a = 30'd42667331;
         4'd5:  a = 30'd21354465;
         4'd6:  a = 30'd10679838;
         4'd7:  a = 30'd5340245;
         4'd8:  a = 30'd2670163;
         4'd9:  a = 30'd1335087;
         4'd10: a = 30'd667544;
         4'd11: a = 30'd333772;
         4'd12: a = 30'd166886;
         4'd13: a = 30'd83443;
         4'd14: a = 30'd41722;
         4'd15: a = 30'd20861;
      endcase
      return a;
   endfunction

   // Saturate a wide signed value to the signed 32-bit range.
   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      logic signed [31:0] r;
      if (v > 64'sh0000_0000_7FFF_FFFF) begin
         r = 32'sh7FFF_FFFF;
      end else if (v < -64'sh0000_0000_8000_0000) begin
         r = -32'sh8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   // Clamp a PD term to plus or minus (2^46 - 1).
   function automatic logic signed [46:0] clamp_pd(input logic signed [63:0] v);
      logic signed [46:0] r;
      if (v > 64'sh0000_3FFF_FFFF_FFFF) begin
         r = 47'sh3FFF_FFFF_FFFF;
      end else if (v < -64'sh0000_3FFF_FFFF_FFFF) begin
         r = -47'sh3FFF_FFFF_FFFF;
      end else begin
         r = v[46:0];
      end
      return r;
   endfunction

   // Round a CORDIC result to Q2.14 and clamp it to one.
   function automatic logic signed [15:0] q14(input logic signed [33:0] v);
      logic signed [33:0] r;
      logic signed [15:0] q;
      r = (v + 34'sd32768) >>> 16;
      if (r > 34'sd16384) begin
         q = 16'sd16384;
      end else if (r < -34'sd16384) begin
         q = -16'sd16384;
      end else begin
         q = r[15:0];
      end
      return q;
   endfunction

endpackage

// ===== design/pd_position_controller.sv =====
// Arm request: taken while idle, no result; the block stays ready.
// Step request: the block is busy from acceptance until the result is committed and takes
// no new request before then; a stalled output register also keeps it busy.
// The work runs on the shared bit-serial 16-bit multiplier (ten products) and the
// restoring divider (one quotient bit a cycle, 50 bits per derivative term).
// Reset is synchronous and active high: gains, period, targets and previous errors return to reset values.
module pd_position_controller #(
   parameter int TRIG_TABLE_BITS = pdpc_pkg::TRIG_TABLE_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_opcode,
   input  logic signed [31:0]                req_pose_x,
   input  logic signed [31:0]                req_pose_y,
   input  logic signed [23:0]                req_pose_heading,
   input  logic signed [31:0]                req_goal_x,
   input  logic signed [31:0]                req_goal_y,
   input  logic signed [23:0]                req_goal_heading,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [31:0]                rsp_speed_x,
   output logic signed [31:0]                rsp_speed_y,
   output logic signed [31:0]                rsp_speed_turn,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [pdpc_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [31:0]                       pwdata,
   output logic [31:0]                       prdata,
   output logic                              pready
);

   localparam int B        = TRIG_TABLE_BITS;
   localparam int NUM_W    = 17 + B;
   localparam int DVD_W    = 50;
   localparam int MUL_LAST = 15;

   localparam logic [4:0] S_IDLE  = 5'd0;
   localparam logic [4:0] S_AXIS  = 5'd1;
   localparam logic [4:0] S_MULD  = 5'd2;
   localparam logic [4:0] S_DLOAD = 5'd3;
   localparam logic [4:0] S_DIVD  = 5'd4;
   localparam logic [4:0] S_PLOAD = 5'd5;
   localparam logic [4:0] S_MULP  = 5'd6;
   localparam logic [4:0] S_STORE = 5'd7;
   localparam logic [4:0] S_MLOAD = 5'd8;
   localparam logic [4:0] S_MOD   = 5'd9;
   localparam logic [4:0] S_ILOAD = 5'd10;
   localparam logic [4:0] S_IDX   = 5'd11;
   localparam logic [4:0] S_CLOAD = 5'd12;
   localparam logic [4:0] S_CORD  = 5'd13;
   localparam logic [4:0] S_TRIG  = 5'd14;
   localparam logic [4:0] S_RLOAD = 5'd15;
   localparam logic [4:0] S_RMUL  = 5'd16;
   localparam logic [4:0] S_RNEXT = 5'd17;
   localparam logic [4:0] S_OUT   = 5'd18;

   // Control registers.
   logic [4:0]  state_ff, state_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [1:0]  axis_ff, axis_in;
   logic [1:0]  rot_ff, rot_in;
   logic        rsp_valid_ff, rsp_valid_in;

   // Configuration and controller state.
   logic signed [15:0] gain_ff [6];
   logic signed [15:0] gain_in [6];
   logic [15:0]        period_ff, period_in;
   logic signed [31:0] target_x_ff, target_x_in, target_y_ff, target_y_in;
   logic signed [23:0] target_h_ff, target_h_in;
   logic signed [32:0] last_ff [3];
   logic signed [32:0] last_in [3];

   // Datapath registers.
   logic signed [32:0] err_ff [3];
   logic signed [32:0] err_in [3];
   logic signed [46:0] pd_ff [3];
   logic signed [46:0] pd_in [3];
   logic signed [23:0] pose_h_ff, pose_h_in;
   logic signed [63:0] mcand_ff, mcand_in, acc_ff, acc_in;
   logic [15:0]        mplier_ff, mplier_in;
   logic [DVD_W-1:0]   dvd_ff, dvd_in, quo_ff, quo_in;
   logic [16:0]        rem_ff, rem_in, dvs_ff, dvs_in;
   logic               neg_ff, neg_in;
   logic signed [33:0] cx_ff, cx_in, cy_ff, cy_in;
   logic signed [32:0] cz_ff, cz_in;
   logic [1:0]         quad_ff, quad_in;
   logic signed [15:0] cos_ff, cos_in, sin_ff, sin_in;
   logic signed [31:0] spx_ff, spx_in, spy_ff, spy_in;
   logic signed [31:0] out_x_ff, out_x_in, out_y_ff, out_y_in, out_t_ff, out_t_in;

   // Shared step logic.
   logic signed [63:0] mul_add;
   logic [17:0]        rem_sh;
   logic               q_bit;
   logic [3:0]         ck;
   logic signed [33:0] xs, ys;
   logic signed [32:0] at;
   logic signed [33:0] diff;
   logic signed [63:0] abs_acc;
   logic [NUM_W-1:0]   num;
   logic [31:0]        phase;
   logic signed [15:0] cr, sr;
   logic [2:0]         csr_idx;
   logic               csr_wr;

   assign req_ready      = (state_ff == S_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_speed_x    = out_x_ff;
   assign rsp_speed_y    = out_y_ff;
   assign rsp_speed_turn = out_t_ff;
   assign pready         = 1'b1;
   assign csr_idx        = paddr[4:2];
   assign csr_wr         = psel & penable & pwrite;

   // Register read-back.
   always_comb begin
      prdata = '0;
      if (csr_idx == pdpc_pkg::CSR_STEP_PERIOD) begin
         prdata = {16'd0, period_ff};
      end else if (csr_idx < pdpc_pkg::CSR_STEP_PERIOD) begin
         prdata = {16'd0, gain_ff[csr_idx]};
      end
   end

   // Bit-serial multiply step: the top multiplier bit carries negative weight.
   always_comb begin
      mul_add = '0;
      if (mplier_ff[0]) begin
         mul_add = (cnt_ff == 6'(MUL_LAST)) ? -mcand_ff : mcand_ff;
      end
   end

   // Restoring divide step: one quotient bit a cycle.
   assign rem_sh = {rem_ff, dvd_ff[DVD_W-1]};
   assign q_bit  = (rem_sh >= {1'b0, dvs_ff});

   // CORDIC step terms.
   assign ck = cnt_ff[3:0];
   assign xs = cx_ff >>> ck;
   assign ys = cy_ff >>> ck;
   assign at = $signed({3'b000, pdpc_pkg::atan_turn(ck)});

   // Miscellaneous operand shaping.
   assign diff    = {err_ff[axis_ff][32], err_ff[axis_ff]}
                  - {last_ff[axis_ff][32], last_ff[axis_ff]};
   assign abs_acc = acc_ff[63] ? -acc_ff : acc_ff;
   assign num     = (NUM_W'(rem_ff) << B) + NUM_W'(pdpc_pkg::HALF_TURN);
   assign phase   = 32'(quo_ff[B-1:0]) << (32 - B);
   assign cr      = pdpc_pkg::q14(cx_ff);
   assign sr      = pdpc_pkg::q14(cy_ff);

   // Next-state and datapath logic.
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      axis_in      = axis_ff;
      rot_in       = rot_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      gain_in      = gain_ff;
      period_in    = period_ff;
      target_x_in  = target_x_ff;
      target_y_in  = target_y_ff;
      target_h_in  = target_h_ff;
      last_in      = last_ff;
      err_in       = err_ff;
      pd_in        = pd_ff;
      pose_h_in    = pose_h_ff;
      mcand_in     = mcand_ff;
      acc_in       = acc_ff;
      mplier_in    = mplier_ff;
      dvd_in       = dvd_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      dvs_in       = dvs_ff;
      neg_in       = neg_ff;
      cx_in        = cx_ff;
      cy_in        = cy_ff;
      cz_in        = cz_ff;
      quad_in      = quad_ff;
      cos_in       = cos_ff;
      sin_in       = sin_ff;
      spx_in       = spx_ff;
      spy_in       = spy_ff;
      out_x_in     = out_x_ff;
      out_y_in     = out_y_ff;
      out_t_in     = out_t_ff;

      // Configuration writes.
      if (csr_wr) begin
         if (csr_idx == pdpc_pkg::CSR_STEP_PERIOD) begin
            period_in = pwdata[15:0];
         end else if (csr_idx < pdpc_pkg::CSR_STEP_PERIOD) begin
            gain_in[csr_idx] = pwdata[15:0];
         end
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_opcode) begin
                  // Arm: latch the target and preset the previous errors.
                  target_x_in = req_goal_x;
                  target_y_in = req_goal_y;
                  target_h_in = req_goal_heading;
                  last_in[0]  = 33'(req_goal_x) - 33'(req_pose_x);
                  last_in[1]  = 33'(req_goal_y) - 33'(req_pose_y);
                  last_in[2]  = 33'(req_goal_heading) - 33'(req_pose_heading);
               end else begin
                  err_in[0] = 33'(target_x_ff) - 33'(req_pose_x);
                  err_in[1] = 33'(target_y_ff) - 33'(req_pose_y);
                  err_in[2] = 33'(target_h_ff) - 33'(req_pose_heading);
                  pose_h_in = req_pose_heading;
                  axis_in   = '0;
                  state_in  = S_AXIS;
               end
            end
         end
         S_AXIS: begin
            // Derivative product first: Kd times the change in error.
            mcand_in  = 64'(diff);
            mplier_in = gain_ff[{axis_ff, 1'b1}];
            acc_in    = '0;
            cnt_in    = '0;
            state_in  = S_MULD;
         end
         S_MULD, S_MULP, S_RMUL: begin
            acc_in    = acc_ff + mul_add;
            mcand_in  = mcand_ff <<< 1;
            mplier_in = mplier_ff >> 1;
            cnt_in    = cnt_ff + 6'd1;
            if (cnt_ff == 6'(MUL_LAST)) begin
               priority case (state_ff)
                  S_MULD:  state_in = S_DLOAD;
                  S_MULP:  state_in = S_STORE;
                  default: state_in = S_RNEXT;
               endcase
            end
         end
         S_DLOAD: begin
            // Divide the magnitude by the period; a zero period counts as one.
            dvd_in   = abs_acc[DVD_W-1:0];
            neg_in   = acc_ff[63];
            dvs_in   = (period_ff == '0) ? 17'd1 : {1'b0, period_ff};
            rem_in   = '0;
            quo_in   = '0;
            cnt_in   = '0;
            state_in = S_DIVD;
         end
         S_DIVD, S_MOD, S_IDX: begin
            rem_in = q_bit ? 17'(rem_sh - {1'b0, dvs_ff}) : rem_sh[16:0];
            quo_in = {quo_ff[DVD_W-2:0], q_bit};
            dvd_in = dvd_ff << 1;
            cnt_in = cnt_ff + 6'd1;
            priority case (state_ff)
               S_DIVD: if (cnt_ff == 6'(DVD_W - 1)) state_in = S_PLOAD;
               S_MOD:  if (cnt_ff == 6'd24) state_in = S_ILOAD;
               default: if (cnt_ff == 6'(NUM_W - 1)) state_in = S_CLOAD;
            endcase
         end
         S_PLOAD: begin
            // Truncated quotient, then Kp times error accumulates on top.
            acc_in    = neg_ff ? -{14'd0, quo_ff} : {14'd0, quo_ff};
            mcand_in  = 64'(err_ff[axis_ff]);
            mplier_in = gain_ff[{axis_ff, 1'b0}];
            cnt_in    = '0;
            state_in  = S_MULP;
         end
         S_STORE: begin
            if (axis_ff == 2'd2) begin
               pd_in[2] = acc_ff[46:0];
               state_in = S_MLOAD;
            end else begin
               pd_in[axis_ff] = pdpc_pkg::clamp_pd(acc_ff);
               axis_in        = axis_ff + 2'd1;
               state_in       = S_AXIS;
            end
         end
         S_MLOAD: begin
            // Heading modulo one turn, after lifting it above zero.
            dvd_in   = {25'({pose_h_ff[23], pose_h_ff}) + pdpc_pkg::TURN_OFFSET, 25'd0};
            dvs_in   = pdpc_pkg::TURN_UNITS;
            rem_in   = '0;
            quo_in   = '0;
            cnt_in   = '0;
            state_in = S_MOD;
         end
         S_ILOAD: begin
            // Round to the nearest table step by dividing by one turn.
            dvd_in   = DVD_W'(num) << (DVD_W - NUM_W);
            rem_in   = '0;
            quo_in   = '0;
            cnt_in   = '0;
            state_in = S_IDX;
         end
         S_CLOAD: begin
            quad_in  = phase[31:30];
            cz_in    = $signed({3'b000, phase[29:0]});
            cx_in    = pdpc_pkg::CORDIC_GAIN;
            cy_in    = '0;
            cnt_in   = '0;
            state_in = S_CORD;
         end
         S_CORD: begin
            if (!cz_ff[32]) begin
               cx_in = cx_ff - ys;
               cy_in = cy_ff + xs;
               cz_in = cz_ff - at;
            end else begin
               cx_in = cx_ff + ys;
               cy_in = cy_ff - xs;
               cz_in = cz_ff + at;
            end
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'(pdpc_pkg::CORDIC_STEPS - 1)) begin
               state_in = S_TRIG;
            end
         end
         S_TRIG: begin
            // Fold the first-quadrant result out to the full turn.
            unique case (quad_ff)
               2'd0: begin cos_in = cr;  sin_in = sr;  end
               2'd1: begin cos_in = -sr; sin_in = cr;  end
               2'd2: begin cos_in = -cr; sin_in = -sr; end
               2'd3: begin cos_in = sr;  sin_in = -cr; end
            endcase
            rot_in   = '0;
            state_in = S_RLOAD;
         end
         S_RLOAD: begin
            // Four products: x*c + y*s, then y*c - x*s.
            unique case (rot_ff)
               2'd0: begin mcand_in = 64'(pd_ff[0]);  mplier_in = cos_ff; end
               2'd1: begin mcand_in = 64'(pd_ff[1]);  mplier_in = sin_ff; end
               2'd2: begin mcand_in = 64'(pd_ff[1]);  mplier_in = cos_ff; end
               2'd3: begin mcand_in = -64'(pd_ff[0]); mplier_in = sin_ff; end
            endcase
            if (!rot_ff[0]) begin
               acc_in = '0;
            end
            cnt_in   = '0;
            state_in = S_RMUL;
         end
         S_RNEXT: begin
            rot_in   = rot_ff + 2'd1;
            state_in = S_RLOAD;
            if (rot_ff == 2'd1) begin
               spx_in = pdpc_pkg::sat32(acc_ff >>> 22);
            end else if (rot_ff == 2'd3) begin
               spy_in   = pdpc_pkg::sat32(acc_ff >>> 22);
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            // Wait for the output register to be free, then commit.
            if (!rsp_valid_ff || rsp_ready) begin
               out_x_in     = spx_ff;
               out_y_in     = spy_ff;
               out_t_in     = pdpc_pkg::sat32(64'(pd_ff[2]) >>> 8);
               rsp_valid_in = 1'b1;
               last_in      = err_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control and state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         axis_ff      <= '0;
         rot_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         gain_ff[0]   <= pdpc_pkg::GAIN_P_RESET;
         gain_ff[1]   <= pdpc_pkg::GAIN_D_RESET;
         gain_ff[2]   <= pdpc_pkg::GAIN_P_RESET;
         gain_ff[3]   <= pdpc_pkg::GAIN_D_RESET;
         gain_ff[4]   <= pdpc_pkg::GAIN_P_RESET;
         gain_ff[5]   <= pdpc_pkg::GAIN_D_RESET;
         period_ff    <= pdpc_pkg::PERIOD_RESET;
         target_x_ff  <= '0;
         target_y_ff  <= '0;
         target_h_ff  <= '0;
         last_ff[0]   <= '0;
         last_ff[1]   <= '0;
         last_ff[2]   <= '0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         axis_ff      <= axis_in;
         rot_ff       <= rot_in;
         rsp_valid_ff <= rsp_valid_in;
         gain_ff      <= gain_in;
         period_ff    <= period_in;
         target_x_ff  <= target_x_in;
         target_y_ff  <= target_y_in;
         target_h_ff  <= target_h_in;
         last_ff      <= last_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      err_ff    <= err_in;
      pd_ff     <= pd_in;
      pose_h_ff <= pose_h_in;
      mcand_ff  <= mcand_in;
      acc_ff    <= acc_in;
      mplier_ff <= mplier_in;
      dvd_ff    <= dvd_in;
      quo_ff    <= quo_in;
      rem_ff    <= rem_in;
      dvs_ff    <= dvs_in;
      neg_ff    <= neg_in;
      cx_ff     <= cx_in;
      cy_ff     <= cy_in;
      cz_ff     <= cz_in;
      quad_ff   <= quad_in;
      cos_ff    <= cos_in;
      sin_ff    <= sin_in;
      spx_ff    <= spx_in;
      spy_ff    <= spy_in;
      out_x_ff  <= out_x_in;
      out_y_ff  <= out_y_in;
      out_t_ff  <= out_t_in;
   end

endmodule

// ===== design/pdpc_checker.sv =====
module pdpc_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input logic                            req_opcode,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic signed [31:0]              rsp_speed_x,
   input logic                            pready
);

   // A step request occupies the block, so it cannot take another at once.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && !req_opcode) |=> !req_ready)
      else $error("block stayed ready after taking a step request");

   // Reset empties the output register.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // The register port never stalls.
   assert property (@(posedge clock) disable iff (reset) pready)
      else $error("register port not ready");

   // A stalled result stays offered and unchanged.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_speed_x)))
      else $error("stalled result dropped or changed");

endmodule

bind pd_position_controller pdpc_checker u_pdpc_checker (.*);
